FILE: design/mbrf_pkg.sv
// Package for the Modbus RTU response framer.
// Holds the result and push types, phase and status codes, register indexes and the CRC step.
// No dependencies.
package mbrf_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] EXC_MASK   = 8'hF0;
	localparam logic [7:0] EXC_CODE   = 8'h80;
	localparam logic [7:0] FC_COIL    = 8'h05;
	localparam logic [7:0] FC_REG     = 8'h06;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef enum logic [2:0] {
		REG_SLAVE_ADDRESS     = 3'd0,
		REG_READ_FUNCTION     = 3'd1,
		REG_WRITE_FUNCTION    = 3'd2,
		REG_TASK_PENDING      = 3'd3,
		REG_TASK_PARAM_LENGTH = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_FUNC = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_CRC_ERROR    = 2'd1,
		ST_UNKNOWN_FUNC = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       end_of_frame;
		logic [1:0] frame_status;
	} mbrf_result_t;

	typedef struct packed {
		logic [1:0]   count;
		mbrf_result_t r0;
		mbrf_result_t r1;
	} mbrf_push_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: design/mbrf_if.sv
// Stream interfaces for the framer: received bytes in, frame results out.
// The result field widths are written out here and do not come from mbrf_pkg.
interface mbrf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface mbrf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       end_of_frame;
	logic [1:0] frame_status;
	modport source(output valid, output frame_byte, output end_of_frame,
		output frame_status, input ready);
	modport sink(input valid, input frame_byte, input end_of_frame,
		input frame_status, output ready);
endinterface

FILE: design/modbus_rtu_response_framer.sv
// Modbus RTU response framer: cuts response frames out of a received byte stream
// and checks their CRC-16. Depends on mbrf_pkg, mbrf_if and mbrf_out_queue.
// Each byte is registered, then framed once the queue has room for two results,
// which are written into the queue. Throughput: one byte per cycle while the queue
// has room, one result out per cycle with tx.ready; a known function code yields two.
// Reset clears the framer to hunting for an address and loads the register defaults.
module modbus_rtu_response_framer (
	input  logic        clk,
	input  logic        arst_n,
	mbrf_in_if.sink     rx,
	mbrf_out_if.source  tx,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] slave_address_q;
	logic [7:0] read_function_q;
	logic [7:0] write_function_q;
	logic       task_pending_q;
	logic [7:0] task_param_length_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fire;
	logic       space_ok;

	mbrf_pkg::phase_t phase_q, phase_d;
	logic [8:0]  byte_index_q, byte_index_d;
	logic [8:0]  frame_length_q, frame_length_d;
	logic        from_count_q, from_count_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;

	logic [8:0]  func_len;
	logic        func_known;
	logic        func_from_count;
	logic [8:0]  eff_len;
	logic [9:0]  index_plus2;
	logic [15:0] rx_crc;

	mbrf_pkg::mbrf_push_t   push;
	mbrf_pkg::mbrf_result_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q     <= 8'd1;
			read_function_q     <= 8'd3;
			write_function_q    <= 8'd16;
			task_pending_q      <= 1'b0;
			task_param_length_q <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mbrf_pkg::REG_SLAVE_ADDRESS:     slave_address_q     <= cfg_data;
				mbrf_pkg::REG_READ_FUNCTION:     read_function_q     <= cfg_data;
				mbrf_pkg::REG_WRITE_FUNCTION:    write_function_q    <= cfg_data;
				mbrf_pkg::REG_TASK_PENDING:      task_pending_q      <= cfg_data[0];
				mbrf_pkg::REG_TASK_PARAM_LENGTH: task_param_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign fire     = valid_s1 && space_ok;
	assign rx.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_comb begin
		func_known      = 1'b1;
		func_from_count = 1'b0;
		func_len        = 9'd0;
		if ((byte_s1 & mbrf_pkg::EXC_MASK) == mbrf_pkg::EXC_CODE) begin
			func_len = 9'd5;
		end else if (byte_s1 == mbrf_pkg::FC_COIL) begin
			func_len = 9'd8;
		end else if (byte_s1 == mbrf_pkg::FC_REG && task_pending_q) begin
			func_len = {1'b0, task_param_length_q} + 9'd6;
		end else if (byte_s1 == read_function_q) begin
			func_len        = 9'd5;
			func_from_count = 1'b1;
		end else if (byte_s1 == write_function_q) begin
			func_len = 9'd8;
		end else begin
			func_known = 1'b0;
		end
	end

	assign eff_len     = (from_count_q && byte_index_q == 9'd2) ?
		({1'b0, byte_s1} + 9'd5) : frame_length_q;
	assign index_plus2 = {1'b0, byte_index_q} + 10'd2;
	assign rx_crc      = {byte_s1, crc_low_q};

	always_comb begin
		phase_d        = phase_q;
		byte_index_d   = byte_index_q;
		frame_length_d = frame_length_q;
		from_count_d   = from_count_q;
		crc_d          = crc_q;
		crc_low_d      = crc_low_q;
		push           = '0;
		if (fire) begin
			unique case (phase_q)
				mbrf_pkg::PH_HUNT: begin
					if (byte_s1 == slave_address_q) begin
						crc_d        = mbrf_pkg::crc_update(mbrf_pkg::CRC_INIT, byte_s1);
						phase_d      = mbrf_pkg::PH_FUNC;
						byte_index_d = 9'd1;
					end
				end
				mbrf_pkg::PH_FUNC: begin
					if (func_known) begin
						push.count     = 2'd2;
						push.r0        = '{slave_address_q, 1'b0, mbrf_pkg::ST_OK};
						push.r1        = '{byte_s1, 1'b0, mbrf_pkg::ST_OK};
						crc_d          = mbrf_pkg::crc_update(crc_q, byte_s1);
						frame_length_d = func_len;
						from_count_d   = func_from_count;
						byte_index_d   = 9'd2;
						phase_d        = mbrf_pkg::PH_BODY;
					end else begin
						push.count     = 2'd1;
						push.r0        = '{byte_s1, 1'b1, mbrf_pkg::ST_UNKNOWN_FUNC};
						phase_d        = mbrf_pkg::PH_HUNT;
						byte_index_d   = '0;
						frame_length_d = '0;
						from_count_d   = 1'b0;
						crc_d          = mbrf_pkg::CRC_INIT;
						crc_low_d      = '0;
					end
				end
				mbrf_pkg::PH_BODY: begin
					frame_length_d = eff_len;
					push.count     = 2'd1;
					if (index_plus2 < {1'b0, eff_len}) begin
						crc_d        = mbrf_pkg::crc_update(crc_q, byte_s1);
						push.r0      = '{byte_s1, 1'b0, mbrf_pkg::ST_OK};
						byte_index_d = byte_index_q + 9'd1;
					end else if (index_plus2 == {1'b0, eff_len}) begin
						crc_low_d    = byte_s1;
						push.r0      = '{byte_s1, 1'b0, mbrf_pkg::ST_OK};
						byte_index_d = byte_index_q + 9'd1;
					end else begin
						push.r0 = '{byte_s1, 1'b1,
							(rx_crc == crc_q) ? mbrf_pkg::ST_OK : mbrf_pkg::ST_CRC_ERROR};
						phase_d        = mbrf_pkg::PH_HUNT;
						byte_index_d   = '0;
						frame_length_d = '0;
						from_count_d   = 1'b0;
						crc_d          = mbrf_pkg::CRC_INIT;
						crc_low_d      = '0;
					end
				end
				default: begin
					phase_d        = mbrf_pkg::PH_HUNT;
					byte_index_d   = '0;
					frame_length_d = '0;
					from_count_d   = 1'b0;
					crc_d          = mbrf_pkg::CRC_INIT;
					crc_low_d      = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= mbrf_pkg::PH_HUNT;
			byte_index_q   <= '0;
			frame_length_q <= '0;
			from_count_q   <= 1'b0;
			crc_q          <= mbrf_pkg::CRC_INIT;
			crc_low_q      <= '0;
		end else begin
			phase_q        <= phase_d;
			byte_index_q   <= byte_index_d;
			frame_length_q <= frame_length_d;
			from_count_q   <= from_count_d;
			crc_q          <= crc_d;
			crc_low_q      <= crc_low_d;
		end
	end

	mbrf_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (tx.valid),
		.out_ready (tx.ready),
		.out_data  (out_data)
	);

	assign tx.frame_byte   = out_data.frame_byte;
	assign tx.end_of_frame = out_data.end_of_frame;
	assign tx.frame_status = out_data.frame_status;

endmodule

FILE: design/mbrf_out_queue.sv
// Small result queue that takes up to two results per cycle and delivers one while out_ready is high.
// Depends on mbrf_pkg for the result and push types.
module mbrf_out_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbrf_pkg::mbrf_push_t  push,
	output logic                  space_ok,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mbrf_pkg::mbrf_result_t out_data
);

	mbrf_pkg::mbrf_result_t entry_q [mbrf_pkg::QUEUE_DEPTH];
	logic [mbrf_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [mbrf_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [mbrf_pkg::QUEUE_AW:0]   count_q;
	logic                          pop;
	logic [mbrf_pkg::QUEUE_AW-1:0] wr_ptr_next1;

	assign out_valid    = (count_q != '0);
	assign out_data     = entry_q[rd_ptr_q];
	assign pop          = out_valid && out_ready;
	assign space_ok     = (count_q <= 3'(mbrf_pkg::QUEUE_DEPTH - 2));
	assign wr_ptr_next1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_ptr_next1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {1'b0, push.count} - {2'b00, pop};
		end
	end

endmodule
